// ===== design/sgi_pkg.sv =====
// Shared types, widths and arithmetic helpers for the segment intersection pipeline.
package sgi_pkg;

   // Width of every coordinate field of the request and the response.
   localparam int COORD_W = 32;
   // Difference of two coordinates.
   localparam int DIFF_W = COORD_W + 1;
   // Product of two differences.
   localparam int PROD_W = 2 * DIFF_W;
   // Side value: difference of two products.
   localparam int SIDE_W = PROD_W + 1;
   // Divider remainder and denominator; one spare bit for the left shift.
   localparam int REM_W = SIDE_W + 1;
   // Width of the interpolation fraction.
   localparam int QUO_W = 32;
   // Default number of quotient bits resolved per divider stage.
   localparam int DIV_STEPS_DEF = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SIDE_W-1:0] side_type;

   typedef struct packed {
      coord_type first_start_x;
      coord_type first_start_y;
      coord_type first_start_z;
      coord_type first_end_x;
      coord_type first_end_y;
      coord_type first_end_z;
      coord_type second_start_x;
      coord_type second_start_y;
      coord_type second_start_z;
      coord_type second_end_x;
      coord_type second_end_y;
      coord_type second_end_z;
   } req_type;

   typedef struct packed {
      logic      hit;
      coord_type cross_x;
      coord_type cross_y;
      coord_type cross_z;
   } rsp_type;

   // Control that travels with each pipeline slot.
   typedef struct packed {
      logic valid;
      logic hit;
   } ctl_type;

   // Segment one, kept as start point plus signed delta (magnitude and sign) per axis.
   typedef struct packed {
      coord_type [2:0]              start;
      logic      [2:0][DIFF_W-1:0]  dmag;
      logic      [2:0]              dneg;
   } ctx_type;

   function automatic diff_type coord_diff(coord_type a, coord_type b);
      diff_type ea;
      diff_type eb;
      ea = $signed({a[COORD_W-1], a});
      eb = $signed({b[COORD_W-1], b});
      return ea - eb;
   endfunction

   function automatic logic [DIFF_W-1:0] diff_mag(diff_type d);
      diff_type n;
      n = -d;
      return d[DIFF_W-1] ? n : d;
   endfunction

   function automatic prod_type diff_mul(diff_type a, diff_type b);
      prod_type ea;
      prod_type eb;
      ea = PROD_W'(a);
      eb = PROD_W'(b);
      return ea * eb;
   endfunction

   function automatic logic [REM_W-1:0] side_mag(side_type s);
      logic [REM_W-1:0] e;
      e = {s[SIDE_W-1], s};
      return s[SIDE_W-1] ? (~e + REM_W'(1)) : e;
   endfunction

endpackage

// ===== design/segment_intersection_2d_core.sv =====
// Top level of the pipelined 2-D segment intersection core.
//
//   Channel   Direction   Ports                              Carries
//   request   in          req_valid, req_ready, req_data     two segments, Q16.16 x/y/z
//   response  out         rsp_valid, rsp_ready, rsp_data     hit flag and crossing point
//
// One transaction enters per clock and one response leaves per clock when the
// consumer keeps rsp_ready high. Each transaction passes through the front end, the
// restoring divider that resolves DIV_STEPS quotient bits per stage, and the back end.
// The whole pipeline moves on one advance signal: it moves whenever the output register
// is empty or being taken, so a stall freezes every stage and nothing is lost or repeated.
// Reset is synchronous and clears only the valid and hit bits; the data registers keep
// whatever they hold, since an invalid slot is never presented.
module segment_intersection_2d_core
   import sgi_pkg::*;
#(
   // Quotient bits per divider stage; must divide QUO_W.
   parameter int DIV_STEPS = DIV_STEPS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   // The output register is the only place a result can wait, so the pipe moves
   // whenever that register is empty or being drained this cycle.
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Divider chain: index 0 is the front end's output, index DIV_STAGES the last stage.
   ctl_type          div_ctl [DIV_STAGES+1];
   logic [REM_W-1:0] div_rem [DIV_STAGES+1];
   logic [REM_W-1:0] div_den [DIV_STAGES+1];
   logic [QUO_W-1:0] div_quo [DIV_STAGES+1];
   ctx_type          div_ctx [DIV_STAGES+1];

   // Front end: four register stages that end with the straddle decision and the
   // divider operands |s| and |s| + |e|.
   sgi_side u_side (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_data  (req_data),
      .ctl_out  (div_ctl[0]),
      .rem_out  (div_rem[0]),
      .den_out  (div_den[0]),
      .ctx_out  (div_ctx[0])
   );

   // The quotient starts empty and collects DIV_STEPS bits in every stage.
   assign div_quo[0] = '0;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      sgi_div_stage #(
         .STEPS (DIV_STEPS)
      ) u_div (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_i   (div_ctl[g]),
         .rem_i   (div_rem[g]),
         .den_i   (div_den[g]),
         .quo_i   (div_quo[g]),
         .ctx_i   (div_ctx[g]),
         .ctl_ff  (div_ctl[g+1]),
         .rem_ff  (div_rem[g+1]),
         .den_ff  (div_den[g+1]),
         .quo_ff  (div_quo[g+1]),
         .ctx_ff  (div_ctx[g+1])
      );
   end

   // Back end: multiply by the fraction, then add the start and zero out misses.
   sgi_lerp u_lerp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl_i     (div_ctl[DIV_STAGES]),
      .quo_i     (div_quo[DIV_STAGES]),
      .ctx_i     (div_ctx[DIV_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A miss must never report a point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |->
         rsp_data.cross_x == '0 && rsp_data.cross_y == '0 && rsp_data.cross_z == '0)
      else $error("miss response carries a nonzero point");

   // On a crossing the fraction |s| / (|s| + |e|) is strictly below one.
   assert property (@(posedge clock) disable iff (reset)
      div_ctl[0].valid && div_ctl[0].hit |-> div_rem[0] < div_den[0])
      else $error("divider operands give a fraction of one or more");

   // A stalled pipe holds the divider's output slot in place.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(div_ctl[DIV_STAGES]) && $stable(div_quo[DIV_STAGES]))
      else $error("divider output moved during a stall");

   // The remainder never reaches the denominator inside the divider on a crossing.
   assert property (@(posedge clock) disable iff (reset)
      div_ctl[DIV_STAGES].valid && div_ctl[DIV_STAGES].hit |->
         div_rem[DIV_STAGES] < div_den[DIV_STAGES])
      else $error("divider remainder out of range");

endmodule

// ===== design/sgi_side.sv =====
// Front end: coordinate differences, cross products, side values and the straddle test.
module sgi_side
   import sgi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  req_type          in_data,
   output ctl_type          ctl_out,
   output logic [REM_W-1:0] rem_out,
   output logic [REM_W-1:0] den_out,
   output ctx_type          ctx_out
);

   // Stage one: differences.
   logic     v1_ff;
   diff_type d1x_ff, d1y_ff, d2x_ff, d2y_ff;
   diff_type ap_x_ff, ap_y_ff, aq_x_ff, aq_y_ff;
   diff_type bp_x_ff, bp_y_ff, bq_x_ff, bq_y_ff;
   ctx_type  ctx1_in, ctx1_ff;
   diff_type dz_in;

   // Stage two: products, two per side value.
   logic     v2_ff;
   prod_type prod_in [8];
   prod_type prod_ff [8];
   ctx_type  ctx2_ff;

   // Stage three: side values s, e, t0, t1.
   logic     v3_ff;
   side_type side_in [4];
   side_type side_ff [4];
   ctx_type  ctx3_ff;

   // Stage four: straddle decision and divider operands.
   ctl_type          ctl4_in, ctl4_ff;
   logic [REM_W-1:0] as_in, ae_in;
   logic [REM_W-1:0] rem4_ff, den4_ff;
   ctx_type          ctx4_ff;
   logic             straddle_one, straddle_two;

   always_comb begin
      dz_in = coord_diff(in_data.first_end_z, in_data.first_start_z);
      ctx1_in.start[0] = in_data.first_start_x;
      ctx1_in.start[1] = in_data.first_start_y;
      ctx1_in.start[2] = in_data.first_start_z;
      ctx1_in.dmag[0]  = diff_mag(coord_diff(in_data.first_end_x, in_data.first_start_x));
      ctx1_in.dmag[1]  = diff_mag(coord_diff(in_data.first_end_y, in_data.first_start_y));
      ctx1_in.dmag[2]  = diff_mag(dz_in);
      ctx1_in.dneg[0]  = coord_diff(in_data.first_end_x, in_data.first_start_x) < 0;
      ctx1_in.dneg[1]  = coord_diff(in_data.first_end_y, in_data.first_start_y) < 0;
      ctx1_in.dneg[2]  = dz_in[DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
      if (advance) begin
         d1x_ff  <= coord_diff(in_data.first_end_x, in_data.first_start_x);
         d1y_ff  <= coord_diff(in_data.first_end_y, in_data.first_start_y);
         d2x_ff  <= coord_diff(in_data.second_end_x, in_data.second_start_x);
         d2y_ff  <= coord_diff(in_data.second_end_y, in_data.second_start_y);
         ap_x_ff <= coord_diff(in_data.first_start_x, in_data.second_start_x);
         ap_y_ff <= coord_diff(in_data.first_start_y, in_data.second_start_y);
         aq_x_ff <= coord_diff(in_data.first_end_x, in_data.second_start_x);
         aq_y_ff <= coord_diff(in_data.first_end_y, in_data.second_start_y);
         bp_x_ff <= coord_diff(in_data.second_start_x, in_data.first_start_x);
         bp_y_ff <= coord_diff(in_data.second_start_y, in_data.first_start_y);
         bq_x_ff <= coord_diff(in_data.second_end_x, in_data.first_start_x);
         bq_y_ff <= coord_diff(in_data.second_end_y, in_data.first_start_y);
         ctx1_ff <= ctx1_in;
      end
   end

   always_comb begin
      prod_in[0] = diff_mul(d2x_ff, ap_y_ff);
      prod_in[1] = diff_mul(d2y_ff, ap_x_ff);
      prod_in[2] = diff_mul(d2x_ff, aq_y_ff);
      prod_in[3] = diff_mul(d2y_ff, aq_x_ff);
      prod_in[4] = diff_mul(d1x_ff, bp_y_ff);
      prod_in[5] = diff_mul(d1y_ff, bp_x_ff);
      prod_in[6] = diff_mul(d1x_ff, bq_y_ff);
      prod_in[7] = diff_mul(d1y_ff, bq_x_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         prod_ff <= prod_in;
         ctx2_ff <= ctx1_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         side_in[k] = $signed({prod_ff[2*k][PROD_W-1], prod_ff[2*k]})
                    - $signed({prod_ff[2*k+1][PROD_W-1], prod_ff[2*k+1]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         side_ff <= side_in;
         ctx3_ff <= ctx2_ff;
      end
   end

   // A crossing needs both endpoints strictly on opposite sides, for both lines.
   always_comb begin
      straddle_one = (side_ff[0] != '0) && (side_ff[1] != '0)
                   && (side_ff[0][SIDE_W-1] != side_ff[1][SIDE_W-1]);
      straddle_two = (side_ff[2] != '0) && (side_ff[3] != '0)
                   && (side_ff[2][SIDE_W-1] != side_ff[3][SIDE_W-1]);
      as_in        = side_mag(side_ff[0]);
      ae_in        = side_mag(side_ff[1]);
      ctl4_in.valid = v3_ff;
      ctl4_in.hit   = straddle_one && straddle_two;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else if (advance) begin
         ctl4_ff <= ctl4_in;
      end
      if (advance) begin
         rem4_ff <= as_in;
         den4_ff <= as_in + ae_in;
         ctx4_ff <= ctx3_ff;
      end
   end

   assign ctl_out = ctl4_ff;
   assign rem_out = rem4_ff;
   assign den_out = den4_ff;
   assign ctx_out = ctx4_ff;

endmodule

// ===== design/sgi_div_stage.sv =====
// One stage of the restoring divider that forms the interpolation fraction.
module sgi_div_stage
   import sgi_pkg::*;
#(
   parameter int STEPS = DIV_STEPS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ctl_type          ctl_i,
   input  logic [REM_W-1:0] rem_i,
   input  logic [REM_W-1:0] den_i,
   input  logic [QUO_W-1:0] quo_i,
   input  ctx_type          ctx_i,
   output ctl_type          ctl_ff,
   output logic [REM_W-1:0] rem_ff,
   output logic [REM_W-1:0] den_ff,
   output logic [QUO_W-1:0] quo_ff,
   output ctx_type          ctx_ff
);

   logic [REM_W-1:0] rem_in;
   logic [QUO_W-1:0] quo_in;

   always_comb begin
      rem_in = rem_i;
      quo_in = quo_i;
      for (int i = 0; i < STEPS; i++) begin
         rem_in = {rem_in[REM_W-2:0], 1'b0};
         if (rem_in >= den_i) begin
            rem_in = rem_in - den_i;
            quo_in = {quo_in[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
      if (advance) begin
         rem_ff <= rem_in;
         den_ff <= den_i;
         quo_ff <= quo_in;
         ctx_ff <= ctx_i;
      end
   end

endmodule

// ===== design/sgi_lerp.sv =====
// Back end: scales segment one's delta by the fraction and adds the start point.
module sgi_lerp
   import sgi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ctl_type          ctl_i,
   input  logic [QUO_W-1:0] quo_i,
   input  ctx_type          ctx_i,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   localparam int MUL_W = QUO_W + DIFF_W;

   ctl_type             ctl1_ff;
   logic [MUL_W-1:0]    mul_in [3];
   logic [DIFF_W-1:0]   ofs_ff [3];
   logic [2:0]          neg_ff;
   coord_type           start_ff [3];

   logic [DIFF_W-1:0]   off_in [3];
   coord_type           pos_in [3];
   rsp_type             rsp_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mul_in[k] = MUL_W'(quo_i) * MUL_W'(ctx_i.dmag[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= ctl_i;
      end
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            ofs_ff[k]   <= mul_in[k][MUL_W-1:QUO_W];
            start_ff[k] <= $signed(ctx_i.start[k]);
         end
         neg_ff <= ctx_i.dneg;
      end
   end

   // The magnitude was truncated before the sign is restored, so rounding is toward zero.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         off_in[k] = neg_ff[k] ? (~ofs_ff[k] + DIFF_W'(1)) : ofs_ff[k];
         pos_in[k] = ctl1_ff.hit ? (start_ff[k] + $signed(off_in[k][COORD_W-1:0])) : '0;
      end
      rsp_in.hit     = ctl1_ff.hit;
      rsp_in.cross_x = pos_in[0];
      rsp_in.cross_y = pos_in[1];
      rsp_in.cross_z = pos_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl1_ff.valid;
      end
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== bench/crossing_checker.sv =====
// Watches both channels of the segment intersection core, predicts each response and compares it.
module crossing_checker
   import sgi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_count
);

   localparam int REPORT_LIMIT = 10;

   rsp_type expected_crossings[$];
   int      fails_seen = 0;
   int      pending_q = 0;

   assign mismatch_count = fails_seen;
   assign pending_count  = pending_q;

   // Side of point p against the line through a and b, kept exact in 128 bits.
   function automatic logic signed [127:0] side_of(coord_type ax, coord_type ay,
                                                   coord_type bx, coord_type by,
                                                   coord_type px, coord_type py);
      logic signed [127:0] wax, way, wbx, wby, wpx, wpy;
      wax = ax; way = ay; wbx = bx; wby = by; wpx = px; wpy = py;
      return (wbx - wax) * (wpy - way) - (wby - way) * (wpx - wax);
   endfunction

   // Point at fraction u of the way from st to en, offset truncated toward zero.
   function automatic coord_type along_first(coord_type st, coord_type en,
                                             logic [31:0] u);
      logic signed [127:0] wst, delta, offset, sum;
      logic [127:0]        span_mag, scaled;
      wst   = st;
      delta = en;
      delta = delta - wst;
      span_mag = (delta < 0) ? -delta : delta;
      scaled = (span_mag * u) >> 32;
      offset = (delta < 0) ? -$signed(scaled) : $signed(scaled);
      sum = wst + offset;
      return sum[COORD_W-1:0];
   endfunction

   function automatic rsp_type predict_crossing(req_type r);
      logic signed [127:0] s_val, e_val, t_start, t_end;
      logic [127:0]        mag_s, mag_e, frac;
      rsp_type             res;
      res = '0;
      s_val   = side_of(r.second_start_x, r.second_start_y, r.second_end_x, r.second_end_y,
                        r.first_start_x, r.first_start_y);
      e_val   = side_of(r.second_start_x, r.second_start_y, r.second_end_x, r.second_end_y,
                        r.first_end_x, r.first_end_y);
      t_start = side_of(r.first_start_x, r.first_start_y, r.first_end_x, r.first_end_y,
                        r.second_start_x, r.second_start_y);
      t_end   = side_of(r.first_start_x, r.first_start_y, r.first_end_x, r.first_end_y,
                        r.second_end_x, r.second_end_y);
      // A touch on either line gives a zero side value and counts as a miss.
      if (s_val == 0 || e_val == 0 || t_start == 0 || t_end == 0) return res;
      if ((s_val < 0) == (e_val < 0) || (t_start < 0) == (t_end < 0)) return res;
      mag_s = (s_val < 0) ? -s_val : s_val;
      mag_e = (e_val < 0) ? -e_val : e_val;
      frac  = (mag_s << 32) / (mag_s + mag_e);
      res.hit     = 1'b1;
      res.cross_x = along_first(r.first_start_x, r.first_end_x, frac[31:0]);
      res.cross_y = along_first(r.first_start_y, r.first_end_y, frac[31:0]);
      res.cross_z = along_first(r.first_start_z, r.first_end_z, frac[31:0]);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      fails;
      fails = fails_seen;
      if (!reset) begin
         if (req_valid && req_ready) expected_crossings.push_back(predict_crossing(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_crossings.size() == 0) begin
               if (fails < REPORT_LIMIT)
                  $display("unexpected response: hit=%0b x=%h y=%h z=%h", rsp_data.hit,
                           rsp_data.cross_x, rsp_data.cross_y, rsp_data.cross_z);
               fails++;
            end else begin
               want = expected_crossings.pop_front();
               if (rsp_data.hit !== want.hit || rsp_data.cross_x !== want.cross_x ||
                   rsp_data.cross_y !== want.cross_y || rsp_data.cross_z !== want.cross_z) begin
                  if (fails < REPORT_LIMIT)
                     $display("crossing mismatch: expected %0b %h %h %h, got %0b %h %h %h",
                              want.hit, want.cross_x, want.cross_y, want.cross_z, rsp_data.hit,
                              rsp_data.cross_x, rsp_data.cross_y, rsp_data.cross_z);
                  fails++;
               end
            end
         end
      end
      fails_seen <= fails;
      pending_q  <= expected_crossings.size();
   end

endmodule

// ===== bench/segment_intersection_2d_core_tb.sv =====
// Stimulus and verdict for the segment intersection core, with the crossing checker beside it.
module segment_intersection_2d_core_tb;
   import sgi_pkg::*;

   // One unit in Q16.16 and the two ends of the coordinate range.
   localparam coord_type ONE  = 32'sh0001_0000;
   localparam coord_type CMAX = 32'sh7fff_ffff;
   localparam coord_type CMIN = 32'sh8000_0000;
   // Random transactions per idling phase; three phases make about 1300 in all.
   localparam int PHASE_PAIRS = 434;
   // Settling time at the end, longer than the pipeline latency at the default divider.
   localparam int DRAIN_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatch_count;
   int      pending_count;
   // Chance in percent that the sender or the receiver holds off in a given cycle.
   int      send_idle_pct = 19;
   int      recv_idle_pct = 46;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   segment_intersection_2d_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   crossing_checker u_crossing_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // The receiver decides afresh every cycle whether it takes a response.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic req_type pair_of(coord_type ax, coord_type ay, coord_type az,
                                       coord_type bx, coord_type by, coord_type bz,
                                       coord_type cx, coord_type cy, coord_type cz,
                                       coord_type dx, coord_type dy, coord_type dz);
      return '{ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz};
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(5))
         0: return CMIN;
         1: return CMAX;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return $urandom;
      endcase
   endfunction

   // Whole units on a tiny grid, so touching, collinear and parallel cases come often.
   function automatic coord_type grid_coord();
      return coord_type'((int'($urandom_range(8)) - 4) * 65536);
   endfunction

   // Random pair. Close to half are built to cross at a chosen point with random content;
   // the rest are raw noise, grid pairs full of degenerate cases, and range extremes.
   function automatic req_type random_pair();
      req_type     p;
      int unsigned kind;
      coord_type   mx, my, vx, vy, wx, wy;
      int unsigned s1, s2, s3, s4;
      for (int i = 0; i < 12; i++) p[i*32 +: 32] = $urandom;
      kind = $urandom_range(99);
      if (kind < 45) begin
         // Both segments pass through m along their own directions, one end on each
         // side, so they cross strictly unless the directions happen to be parallel.
         mx = $signed($urandom) >>> 2;  my = $signed($urandom) >>> 2;
         vx = $signed($urandom) >>> 2;  vy = $signed($urandom) >>> 2;
         wx = $signed($urandom) >>> 2;  wy = $signed($urandom) >>> 2;
         s1 = $urandom_range(4); s2 = $urandom_range(4);
         s3 = $urandom_range(4); s4 = $urandom_range(4);
         p.first_start_x  = mx - (vx >>> s1);  p.first_start_y  = my - (vy >>> s1);
         p.first_end_x    = mx + (vx >>> s2);  p.first_end_y    = my + (vy >>> s2);
         p.second_start_x = mx - (wx >>> s3);  p.second_start_y = my - (wy >>> s3);
         p.second_end_x   = mx + (wx >>> s4);  p.second_end_y   = my + (wy >>> s4);
      end else if (kind < 65) begin
         // Keep the raw random fields.
      end else if (kind < 85) begin
         p.first_start_x  = grid_coord();  p.first_start_y  = grid_coord();
         p.first_end_x    = grid_coord();  p.first_end_y    = grid_coord();
         p.second_start_x = grid_coord();  p.second_start_y = grid_coord();
         p.second_end_x   = grid_coord();  p.second_end_y   = grid_coord();
      end else begin
         p.first_start_x  = extreme_coord();  p.first_start_y  = extreme_coord();
         p.first_start_z  = extreme_coord();  p.first_end_z    = extreme_coord();
         p.first_end_x    = extreme_coord();  p.first_end_y    = extreme_coord();
         p.second_start_x = extreme_coord();  p.second_start_y = extreme_coord();
         p.second_end_x   = extreme_coord();  p.second_end_y   = extreme_coord();
      end
      return p;
   endfunction

   // Offer one transaction after a random hold-off and wait for the handshake.
   // Valid only drops when a hold-off is actually taken, so it never falls and rises
   // again in the same time step.
   task automatic send_pair(input req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every predicted response has come back.
   // The first edge is always taken because the checker's count is registered.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions: simple and full-range crossings, touches, collinear,
      // parallel and zero-length segments, crossings near either end of segment one,
      // truncation of a falling z, and ignored z fields on segment two.
      send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pair_of(-ONE, -ONE, 0, ONE, ONE, 4*ONE, -ONE, ONE, 0, ONE, -ONE, 0));
      send_pair(pair_of(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN));
      send_pair(pair_of(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 0, CMIN, CMAX, -1));
      send_pair(pair_of(0, 0, 0, 4*ONE, 0, ONE, 2*ONE, 0, 0, 2*ONE, 3*ONE, 0));
      send_pair(pair_of(0, 0, 0, 2*ONE, 0, 0, 2*ONE, -ONE, 0, 2*ONE, ONE, 0));
      send_pair(pair_of(0, 0, 0, 4*ONE, 4*ONE, ONE, ONE, ONE, 0, 3*ONE, 3*ONE, 0));
      send_pair(pair_of(0, 0, 0, 4*ONE, 0, ONE, 0, ONE, 0, 4*ONE, ONE, 0));
      send_pair(pair_of(ONE, 0, ONE, ONE, 0, ONE, 0, -ONE, 0, 2*ONE, ONE, 0));
      send_pair(pair_of(0, 0, 0, ONE, 0, ONE, 5*ONE, -ONE, 0, 5*ONE, ONE, 0));
      send_pair(pair_of(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, 0, CMAX, CMAX, 0));
      send_pair(pair_of(0, 0, 0, 1000, 0, CMAX, 999, -1, 0, 999, 1, 0));
      send_pair(pair_of(0, 0, CMIN, 1000, 0, CMAX, 1, -1, 0, 1, 1, 0));
      send_pair(pair_of(0, 0, 5, 3, 0, 0, 1, -1, 0, 1, 1, 0));
      send_pair(pair_of(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      send_pair(pair_of(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
      send_pair(pair_of(-ONE, 0, 7, ONE, 0, -7, 0, -ONE, CMIN, 0, ONE, CMAX));
      send_pair(pair_of(CMIN, CMIN, 0, CMAX, CMAX, -ONE, CMIN, CMIN + 1, 0, CMAX, CMAX - 1, 0));
      send_pair(pair_of(CMIN, 0, 0, CMAX, 0, 0, 0, CMIN, 0, 0, CMAX, 0));

      // Random transactions in three idling phases: sender light and receiver heavy,
      // then the reverse, then no idling on either side. Each phase ends with the
      // sender holding off until the pipeline has fully drained.
      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < PHASE_PAIRS; n++) send_pair(random_pair());
         wait_for_results();
         send_idle_pct = (phase == 0) ? 46 : 0;
         recv_idle_pct <= (phase == 0) ? 19 : 0;
      end

      // Everything is back; give any stray response time to show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Hang guard: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sgi_pkg.sv
design/sgi_side.sv
design/sgi_div_stage.sv
design/sgi_lerp.sv
design/segment_intersection_2d_core.sv
bench/crossing_checker.sv
bench/segment_intersection_2d_core_tb.sv
